FILE: hw/rtl/sgmp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the stroke-gated mosaic pixelate unit.
// No dependencies.
package sgmp_pkg;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int MAX_BLOCK_DEF = 64;
  localparam int HEIGHT_LIMIT  = 4096;
  localparam int SUM_W         = 20;
  localparam int AVG_W         = 8;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 13;
  localparam int QUEUE_DEPTH   = 4;

  localparam int BLOCK_SIZE_RST   = 8;
  localparam int IMAGE_WIDTH_RST  = 1024;
  localparam int IMAGE_HEIGHT_RST = 1024;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       stroke_hit;
    logic       already_mosaic;
  } pixel_t;

  typedef struct packed {
    logic [11:0] block_left;
    logic [11:0] block_top;
    logic [6:0]  block_width;
    logic [6:0]  block_height;
    logic [7:0]  avg_red;
    logic [7:0]  avg_green;
    logic [7:0]  avg_blue;
  } block_t;

endpackage

FILE: hw/rtl/sgmp_fifo.sv
`timescale 1ns / 1ps
// Small queue of finished block records between front and back.
// Uses sgmp_pkg only through its parameters' defaults.
module sgmp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = sgmp_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("pop from empty queue");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not follow push");

endmodule

FILE: hw/rtl/sgmp_front.sv
`timescale 1ns / 1ps
// Front end: pixel position tracking, per-block-column accumulation memory,
// block completion test. Depends on sgmp_pkg.
module sgmp_front #(
  parameter int MAX_WIDTH = sgmp_pkg::MAX_WIDTH_DEF,
  parameter int MAX_BLOCK = sgmp_pkg::MAX_BLOCK_DEF,
  parameter int REC_W     = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sgmp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sgmp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  sgmp_pkg::pixel_t                in_data,
  output logic                            push,
  output logic [REC_W-1:0]                push_data,
  input  logic                            queue_full
);

  localparam int XW = $clog2(MAX_WIDTH) + 1;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int BW = $clog2(MAX_BLOCK) + 1;
  localparam int YW = $clog2(sgmp_pkg::HEIGHT_LIMIT) + 1;
  localparam int SW = sgmp_pkg::SUM_W;
  localparam int MW = 3 * SW + 2;

  typedef enum logic {S_ACC, S_UPD} state_t;

  state_t state;
  logic [6:0]  blk_size_reg;
  logic [12:0] width_reg;
  logic [12:0] height_reg;

  logic [XW-1:0] x, left;
  logic [YW-1:0] y, top;
  logic [BW-1:0] xin, yin;
  logic [CW-1:0] col;
  sgmp_pkg::pixel_t pix;

  logic [MW-1:0] mem [MAX_WIDTH];
  logic [MW-1:0] rd;

  logic [BW-1:0] bs;
  logic [XW-1:0] w_eff, rem_w;
  logic [YW-1:0] h_eff, rem_h;
  logic [BW-1:0] bw, bh;
  logic          first, last, any_c, all_d, emit, step;
  logic [SW-1:0] sr, sg, sb;

  always_comb begin
    if (blk_size_reg == '0) bs = BW'(1);
    else if (32'(blk_size_reg) > 32'(MAX_BLOCK)) bs = BW'(MAX_BLOCK);
    else bs = BW'(blk_size_reg);
    if (width_reg == '0) w_eff = XW'(1);
    else if (32'(width_reg) > 32'(MAX_WIDTH)) w_eff = XW'(MAX_WIDTH);
    else w_eff = XW'(width_reg);
    if (height_reg == '0) h_eff = YW'(1);
    else if (32'(height_reg) > 32'(sgmp_pkg::HEIGHT_LIMIT)) h_eff = YW'(sgmp_pkg::HEIGHT_LIMIT);
    else h_eff = YW'(height_reg);
    rem_w = w_eff - left;
    rem_h = h_eff - top;
    bw = (32'(rem_w) < 32'(bs)) ? BW'(rem_w) : bs;
    bh = (32'(rem_h) < 32'(bs)) ? BW'(rem_h) : bs;
    first = (xin == '0) && (yin == '0);
    last  = (xin == bw - 1'b1) && (yin == bh - 1'b1);
    sr = (first ? '0 : rd[MW-1 -: SW]) + SW'(pix.red);
    sg = (first ? '0 : rd[MW-1-SW -: SW]) + SW'(pix.green);
    sb = (first ? '0 : rd[MW-1-2*SW -: SW]) + SW'(pix.blue);
    any_c = (first ? 1'b0 : rd[1]) | pix.stroke_hit;
    all_d = (first ? 1'b1 : rd[0]) & pix.already_mosaic;
    emit = last && any_c && !all_d;
    step = (state == S_UPD) && !(emit && queue_full);
  end

  assign in_stall  = (state != S_ACC);
  assign push      = step && emit;
  assign push_data = {12'(left), 12'(top), bw, bh, sr, sg, sb};

  always_ff @(posedge clk) begin
    if (state == S_ACC && in_valid) begin
      rd  <= mem[col];
      pix <= in_data;
    end
    if (step) begin
      mem[col] <= {sr, sg, sb, any_c, all_d};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_ACC;
      blk_size_reg <= 7'(sgmp_pkg::BLOCK_SIZE_RST);
      width_reg    <= 13'(sgmp_pkg::IMAGE_WIDTH_RST);
      height_reg   <= 13'(sgmp_pkg::IMAGE_HEIGHT_RST);
      x <= '0; y <= '0; xin <= '0; yin <= '0; col <= '0; left <= '0; top <= '0;
    end else if (cfg_we) begin
      // any write restarts the frame
      if (cfg_index == sgmp_pkg::REG_BLOCK_SIZE) blk_size_reg <= cfg_data[6:0];
      if (cfg_index == sgmp_pkg::REG_IMAGE_WIDTH) width_reg <= cfg_data;
      if (cfg_index == sgmp_pkg::REG_IMAGE_HEIGHT) height_reg <= cfg_data;
      x <= '0; y <= '0; xin <= '0; yin <= '0; col <= '0; left <= '0; top <= '0;
    end else begin
      case (state)
        S_ACC: begin
          if (in_valid) state <= S_UPD;
        end
        S_UPD: begin
          if (step) begin
            state <= S_ACC;
            if (x + 1'b1 == w_eff) begin
              x <= '0; xin <= '0; col <= '0; left <= '0;
              if (y + 1'b1 == h_eff) begin
                y <= '0; yin <= '0; top <= '0;
              end else begin
                y <= y + 1'b1;
                if (yin + 1'b1 == bs) begin
                  yin <= '0;
                  top <= top + YW'(bs);
                end else begin
                  yin <= yin + 1'b1;
                end
              end
            end else begin
              x <= x + 1'b1;
              if (xin + 1'b1 == bs) begin
                xin  <= '0;
                col  <= col + 1'b1;
                left <= left + XW'(bs);
              end else begin
                xin <= xin + 1'b1;
              end
            end
          end
        end
        default: state <= S_ACC;
      endcase
    end
  end

endmodule

FILE: hw/rtl/sgmp_back.sv
`timescale 1ns / 1ps
// Back end: pixel count, bit-serial division of the three channel sums,
// output register. Depends on sgmp_pkg.
module sgmp_back #(
  parameter int MAX_BLOCK = sgmp_pkg::MAX_BLOCK_DEF,
  parameter int REC_W     = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             queue_empty,
  input  logic [REC_W-1:0] queue_data,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output sgmp_pkg::block_t out_data
);

  localparam int BW = $clog2(MAX_BLOCK) + 1;
  localparam int SW = sgmp_pkg::SUM_W;
  localparam int AW = sgmp_pkg::AVG_W;

  typedef enum logic [1:0] {B_IDLE, B_MUL, B_DIV, B_OUT} state_t;

  state_t state;
  logic [11:0]     left, top;
  logic [BW-1:0]   bw, bh;
  logic [SW-1:0]   rem_r, rem_g, rem_b;
  logic [2*BW-1:0] count;
  logic [AW-1:0]   q_r, q_g, q_b;
  logic [$clog2(AW)-1:0] bit_idx;
  logic [31:0]     dsh;

  assign pop       = (state == B_IDLE) && !queue_empty;
  assign out_valid = (state == B_OUT);
  assign dsh       = 32'(count) << bit_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      case (state)
        B_IDLE: begin
          if (!queue_empty) begin
            {left, top, bw, bh, rem_r, rem_g, rem_b} <= queue_data;
            state <= B_MUL;
          end
        end
        B_MUL: begin
          count   <= bw * bh;
          bit_idx <= '1;
          state   <= B_DIV;
        end
        B_DIV: begin
          // restoring division, one quotient bit per cycle for all channels
          q_r[bit_idx] <= (32'(rem_r) >= dsh);
          q_g[bit_idx] <= (32'(rem_g) >= dsh);
          q_b[bit_idx] <= (32'(rem_b) >= dsh);
          if (32'(rem_r) >= dsh) rem_r <= SW'(32'(rem_r) - dsh);
          if (32'(rem_g) >= dsh) rem_g <= SW'(32'(rem_g) - dsh);
          if (32'(rem_b) >= dsh) rem_b <= SW'(32'(rem_b) - dsh);
          if (bit_idx == '0) state <= B_OUT;
          else bit_idx <= bit_idx - 1'b1;
        end
        B_OUT: begin
          if (!out_stall) state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_comb begin
    out_data.block_left   = left;
    out_data.block_top    = top;
    out_data.block_width  = 7'(bw);
    out_data.block_height = 7'(bh);
    out_data.avg_red      = q_r;
    out_data.avg_green    = q_g;
    out_data.avg_blue     = q_b;
  end

endmodule

FILE: hw/rtl/stroke_gated_mosaic_pixelate_unit.sv
`timescale 1ns / 1ps
// Front end reads the column memory when it takes a pixel, then updates/writes it,
// holding in_stall until the write; the write waits while a block is to be emitted into
// a full queue of sgmp_pkg::QUEUE_DEPTH records. Per block the back end pops the record,
// counts pixels, runs 8 divide steps and holds the output until it is taken.
// Synchronous reset clears position, registers to defaults and control; the
// column memory has no reset.
module stroke_gated_mosaic_pixelate_unit #(
  parameter int MAX_WIDTH = sgmp_pkg::MAX_WIDTH_DEF,
  parameter int MAX_BLOCK = sgmp_pkg::MAX_BLOCK_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sgmp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sgmp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  sgmp_pkg::pixel_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output sgmp_pkg::block_t                out_data
);

  localparam int BW    = $clog2(MAX_BLOCK) + 1;
  localparam int REC_W = 24 + 2 * BW + 3 * sgmp_pkg::SUM_W;

  logic             push, pop, full, empty;
  logic [REC_W-1:0] push_data, pop_data;

  sgmp_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_BLOCK(MAX_BLOCK), .REC_W(REC_W)) u_front (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .in_data,
    .push, .push_data, .queue_full(full)
  );

  sgmp_fifo #(.WIDTH(REC_W), .DEPTH(sgmp_pkg::QUEUE_DEPTH)) u_fifo (
    .clk, .rst, .push, .push_data, .pop, .pop_data, .full, .empty
  );

  sgmp_back #(.MAX_BLOCK(MAX_BLOCK), .REC_W(REC_W)) u_back (
    .clk, .rst, .queue_empty(empty), .queue_data(pop_data), .pop,
    .out_valid, .out_stall, .out_data
  );

endmodule
